// ----- src/bezier_degree_elevation_defines.svh -----
// ----------------------------------------------------------------------------
// Bezier degree elevation: assertion macros
// Concurrent checks that compile away when SYNTHESIS is set.
// ----------------------------------------------------------------------------
`ifndef BEZIER_DEGREE_ELEVATION_DEFINES_SVH
`define BEZIER_DEGREE_ELEVATION_DEFINES_SVH

`ifndef SYNTHESIS
// Same-cycle implication, disabled while reset is asserted.
`define BDE_ASSERT_IMP(lbl, ck, rn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
		else $error("bde: same-cycle check failed");
// Next-cycle implication, disabled while reset is asserted.
`define BDE_ASSERT_NXT(lbl, ck, rn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
		else $error("bde: next-cycle check failed");
`else
`define BDE_ASSERT_IMP(lbl, ck, rn, ante, cons)
`define BDE_ASSERT_NXT(lbl, ck, rn, ante, cons)
`endif

`endif

// ----- src/bde_pkg.sv -----
// ----------------------------------------------------------------------------
// Bezier degree elevation package
// Widths, register codes, payload types and control types.
// ----------------------------------------------------------------------------
`default_nettype none

package bde_pkg;

	localparam int COORD_W    = 32;
	localparam int LANES      = 4;
	localparam int LANE_W     = 2;
	localparam int MAX_DEGREE = 15;
	localparam int DEG_W      = 4;
	localparam int DIM_W      = 3;
	localparam int M_W        = DEG_W + 1;
	localparam int IDX_W      = 5;
	localparam int FRAC_W     = 16;
	localparam int DIV_CNT_W  = $clog2(FRAC_W);
	localparam int DIFF_W     = COORD_W + 1;
	localparam int PROD_W     = DIFF_W + FRAC_W + 1;
	localparam int CFG_W      = 4;
	localparam int CFG_IDX_W  = 1;

	localparam logic [CFG_IDX_W-1:0] CFG_CURVE_DEGREE    = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_DIMENSION_COUNT = 1'b1;

	typedef logic signed [COORD_W-1:0] coord_t;

	typedef struct packed {
		coord_t coord_x;
		coord_t coord_y;
		coord_t coord_z;
		coord_t coord_w;
	} pt_in_t;

	typedef struct packed {
		coord_t             out_x;
		coord_t             out_y;
		coord_t             out_z;
		coord_t             out_w;
		logic [IDX_W-1:0]   point_index;
		logic               last_point;
	} pt_out_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CHECK,
		ST_DIV,
		ST_MUL,
		ST_DRAIN,
		ST_PUT1,
		ST_PUT2
	} bde_state_t;

	typedef struct packed {
		logic              take;
		logic              div_go;
		logic              mul_go;
		logic [LANE_W-1:0] mul_lane;
		logic              put_blend;
		logic              put_tail;
	} bde_cmd_t;

	typedef struct packed {
		logic first;
		logic last;
		logic div_done;
		logic out_free;
	} bde_sts_t;

endpackage

`default_nettype wire

// ----- src/bde_in_if.sv -----
// ----------------------------------------------------------------------------
// Control point channel
// Valid/ready channel that carries one input control point.
// ----------------------------------------------------------------------------
`default_nettype none

interface bde_in_if import bde_pkg::*; ();
	logic   valid;
	logic   ready;
	pt_in_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

// ----- src/bde_out_if.sv -----
// ----------------------------------------------------------------------------
// Elevated point channel
// Valid/ready channel that carries one elevated control point.
// ----------------------------------------------------------------------------
`default_nettype none

interface bde_out_if import bde_pkg::*; ();
	logic    valid;
	logic    ready;
	pt_out_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

// ----- src/bde_div.sv -----
// ----------------------------------------------------------------------------
// Blend weight divider
// Restoring divider, one quotient bit per cycle, for alpha = N / (n+1).
// ----------------------------------------------------------------------------
`default_nettype none

module bde_div import bde_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	input  wire logic [DEG_W-1:0]  num_hi,
	input  wire logic [FRAC_W-1:0] num_lo,
	input  wire logic [M_W-1:0]    den,
	output logic                   done,
	output logic [FRAC_W-1:0]      quot
);

	logic                 busy_q;
	logic                 done_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic [M_W-1:0]       rem_q;
	logic [FRAC_W-1:0]    lo_q;
	logic [FRAC_W-1:0]    quo_q;

	logic [M_W:0] trial;
	logic [M_W:0] trial_sub;
	logic         q_bit;

	// The remainder always stays below the divisor, so one extra bit holds the trial.
	assign trial     = {rem_q, lo_q[FRAC_W-1]};
	assign trial_sub = trial - {1'b0, den};
	assign q_bit     = (trial >= {1'b0, den});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + DIV_CNT_W'(1);
				if (cnt_q == DIV_CNT_W'(FRAC_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= M_W'(num_hi);
			lo_q  <= num_lo;
			quo_q <= '0;
		end else if (busy_q) begin
			rem_q <= q_bit ? trial_sub[M_W-1:0] : trial[M_W-1:0];
			lo_q  <= {lo_q[FRAC_W-2:0], 1'b0};
			quo_q <= {quo_q[FRAC_W-2:0], q_bit};
		end
	end

	assign done = done_q;
	assign quot = quo_q;

endmodule

`default_nettype wire

// ----- src/bde_ctrl.sv -----
// ----------------------------------------------------------------------------
// Bezier degree elevation controller
// Sequences take, divide, per-lane blend and the one or two output loads.
// ----------------------------------------------------------------------------
`default_nettype none

module bde_ctrl import bde_pkg::*; (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     in_valid,
	output logic          in_ready,
	input  wire bde_sts_t sts,
	output bde_cmd_t      cmd
);

	bde_state_t        state_q;
	bde_state_t        state_d;
	logic [LANE_W-1:0] lane_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			lane_q  <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_MUL) begin
				lane_q <= lane_q + LANE_W'(1);
			end else begin
				lane_q <= '0;
			end
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.take = 1'b1;
					state_d  = ST_CHECK;
				end
			end
			ST_CHECK: begin
				if (sts.first) begin
					state_d = ST_PUT1;
				end else begin
					cmd.div_go = 1'b1;
					state_d    = ST_DIV;
				end
			end
			ST_DIV: begin
				if (sts.div_done) begin
					state_d = ST_MUL;
				end
			end
			ST_MUL: begin
				cmd.mul_go   = 1'b1;
				cmd.mul_lane = lane_q;
				if (lane_q == LANE_W'(LANES - 1)) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				state_d = ST_PUT1;
			end
			ST_PUT1: begin
				if (sts.out_free) begin
					cmd.put_blend = 1'b1;
					state_d       = sts.last ? ST_PUT2 : ST_IDLE;
				end
			end
			ST_PUT2: begin
				if (sts.out_free) begin
					cmd.put_tail = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

`default_nettype wire

// ----- src/bde_datapath.sv -----
// ----------------------------------------------------------------------------
// Bezier degree elevation datapath
// Configuration, point and index state, blend lanes and output register.
// ----------------------------------------------------------------------------
`default_nettype none

module bde_datapath import bde_pkg::*; (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_we,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [CFG_W-1:0]     cfg_data,
	input  wire pt_in_t               in_data,
	input  wire logic                 out_ready,
	output logic                      out_valid,
	output pt_out_t                   out_data,
	input  wire bde_cmd_t             cmd,
	output bde_sts_t                  sts
);

	localparam logic [FRAC_W-1:0] HALF_LSB = FRAC_W'(1) << (FRAC_W - 1);

	logic [DEG_W-1:0] deg_q;
	logic [DIM_W-1:0] dim_q;
	logic [DEG_W-1:0] idx_q;
	logic [DEG_W-1:0] k_q;
	logic             first_q;
	logic             last_q;
	coord_t           prev_q [LANES];
	coord_t           res_q  [LANES];
	logic signed [DIFF_W-1:0] diff_q [LANES];

	logic                     mvalid_s1;
	logic [LANE_W-1:0]        lane_s1;
	logic signed [PROD_W-1:0] prod_s1;

	logic                 out_valid_q;
	pt_out_t              out_q;

	coord_t               cur     [LANES];
	coord_t               sel_out [LANES];
	logic [LANES-1:0]     lane_en;
	logic [DEG_W-1:0]     k_eff;
	logic [M_W-1:0]       m_val;
	logic [FRAC_W-1:0]    alpha;
	logic                 div_done;
	coord_t               blend_cur;
	logic signed [PROD_W-1:0] blend_sum;

	assign cur[0] = in_data.coord_x;
	assign cur[1] = in_data.coord_y;
	assign cur[2] = in_data.coord_z;
	assign cur[3] = in_data.coord_w;

	// A stale index above a lowered degree restarts the curve.
	assign k_eff = (idx_q > deg_q) ? '0 : idx_q;
	assign m_val = M_W'(deg_q) + M_W'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			deg_q <= DEG_W'(3);
			dim_q <= DIM_W'(3);
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_CURVE_DEGREE: begin
					deg_q <= (cfg_data > CFG_W'(MAX_DEGREE)) ? DEG_W'(MAX_DEGREE)
						: cfg_data[DEG_W-1:0];
				end
				CFG_DIMENSION_COUNT: begin
					dim_q <= (cfg_data[DIM_W-1:0] > DIM_W'(LANES)) ? DIM_W'(LANES)
						: cfg_data[DIM_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q   <= '0;
			first_q <= 1'b0;
			last_q  <= 1'b0;
		end else if (cmd.take) begin
			idx_q   <= (k_eff == deg_q) ? '0 : k_eff + DEG_W'(1);
			first_q <= (k_eff == '0);
			last_q  <= (k_eff == deg_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int l = 0; l < LANES; l++) begin
				prev_q[l] <= '0;
			end
		end else if (cmd.take) begin
			for (int l = 0; l < LANES; l++) begin
				prev_q[l] <= cur[l];
			end
		end
	end

	bde_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.div_go),
		.num_hi (k_q),
		.num_lo (FRAC_W'(m_val[M_W-1:1])),
		.den    (m_val),
		.done   (div_done),
		.quot   (alpha)
	);

	// Q = cur + alpha * (prev - cur), rounded: the constant half LSB rides in the
	// otherwise empty fraction bits of cur, so one add finishes the lane.
	assign blend_cur = res_q[lane_s1];
	assign blend_sum = $signed({{(PROD_W - COORD_W - FRAC_W){blend_cur[COORD_W-1]}},
		blend_cur, HALF_LSB}) + prod_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mvalid_s1 <= 1'b0;
		end else begin
			mvalid_s1 <= cmd.mul_go;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.take) begin
			k_q <= k_eff;
			for (int l = 0; l < LANES; l++) begin
				res_q[l]  <= cur[l];
				diff_q[l] <= {prev_q[l][COORD_W-1], prev_q[l]} - {cur[l][COORD_W-1], cur[l]};
			end
		end else if (mvalid_s1) begin
			res_q[lane_s1] <= blend_sum[FRAC_W +: COORD_W];
		end
		if (cmd.mul_go) begin
			lane_s1 <= cmd.mul_lane;
			prod_s1 <= diff_q[cmd.mul_lane] * $signed({1'b0, alpha});
		end
	end

	always_comb begin
		for (int l = 0; l < LANES; l++) begin
			lane_en[l] = ({1'b0, LANE_W'(l)} < dim_q);
			if (!lane_en[l]) begin
				sel_out[l] = '0;
			end else if (cmd.put_tail) begin
				sel_out[l] = prev_q[l];
			end else begin
				sel_out[l] = res_q[l];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.put_blend || cmd.put_tail) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.put_blend || cmd.put_tail) begin
			out_q.out_x       <= sel_out[0];
			out_q.out_y       <= sel_out[1];
			out_q.out_z       <= sel_out[2];
			out_q.out_w       <= sel_out[3];
			out_q.point_index <= cmd.put_tail ? IDX_W'(deg_q) + IDX_W'(1) : IDX_W'(k_q);
			out_q.last_point  <= cmd.put_tail;
		end
	end

	assign out_valid    = out_valid_q;
	assign out_data     = out_q;
	assign sts.first    = first_q;
	assign sts.last     = last_q;
	assign sts.div_done = div_done;
	assign sts.out_free = !out_valid_q || out_ready;

endmodule

`default_nettype wire

// ----- src/bezier_degree_elevation.sv -----
// ----------------------------------------------------------------------------
// Bezier degree elevation
// Streams the n+2 control points of the elevated curve from n+1 input points.
// ----------------------------------------------------------------------------
//
//   Channel    Dir  Handshake          Payload
//   ---------  ---  -----------------  -----------------------------------------
//   ctrl_pts   in   valid / ready      coord_x, coord_y, coord_z, coord_w
//   elev_pts   out  valid / ready      out_x..out_w, point_index, last_point
//   cfg        in   cfg_we             cfg_index, cfg_data (write only)
//
// The first point of a curve goes from take through check straight to the
// output load. Every later point is taken and checked, then passes the serial divider that
// forms alpha = k/(n+1) one quotient bit per cycle, then the single shared
// multiplier that blends one lane per cycle, a drain step and the load.
// The final point of a curve then loads a second result, the closing point.
// Reset clears the control state, the stored point and the index, and sets the
// degree and dimension registers to 3. Output stalls back up only once the
// single output register is full and a new result is ready to load.
// ----------------------------------------------------------------------------
`default_nettype none

`include "bezier_degree_elevation_defines.svh"

module bezier_degree_elevation import bde_pkg::*; (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_we,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [CFG_W-1:0]     cfg_data,
	bde_in_if.sink                    ctrl_pts,
	bde_out_if.source                 elev_pts
);

	// Commands from the sequencer and status back from the datapath.
	bde_cmd_t cmd;
	bde_sts_t sts;

	// The controller accepts a request only when the previous point is fully
	// handed to the output register, so at most one item is in flight.
	bde_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (ctrl_pts.valid),
		.in_ready (ctrl_pts.ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// The datapath keeps the configuration, the previous point and the point
	// index, runs the divider and blend lanes, and owns the output register
	// that lets a new request in while a result still waits downstream.
	bde_datapath u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_data   (ctrl_pts.data),
		.out_ready (elev_pts.ready),
		.out_valid (elev_pts.valid),
		.out_data  (elev_pts.data),
		.cmd       (cmd),
		.sts       (sts)
	);

	// A new point never lands in the same cycle as an output load.
	`BDE_ASSERT_IMP(a_no_put_on_take, clk, arst_n, cmd.take, !(cmd.put_blend || cmd.put_tail))
	// After a request is taken the block works on it before taking another.
	`BDE_ASSERT_NXT(a_one_in_flight, clk, arst_n, ctrl_pts.valid && ctrl_pts.ready, !ctrl_pts.ready)
	// The closing point is only produced for the last input of a curve.
	`BDE_ASSERT_IMP(a_tail_only_last, clk, arst_n, cmd.put_tail, sts.last)
	// The closing point of the elevated curve never carries index zero.
	`BDE_ASSERT_IMP(a_last_index, clk, arst_n, elev_pts.valid && elev_pts.data.last_point, elev_pts.data.point_index != '0)

endmodule

`default_nettype wire

// ----- sim/bezier_degree_elevation_tb.sv -----
// ----------------------------------------------------------------------------
// Bezier degree elevation testbench
// Streams control points of curves of degrees zero to six and fifteen, and of every lane count, through the
// block and checks each elevated point against a local fixed-point predictor.
// ----------------------------------------------------------------------------

module bezier_degree_elevation_tb;
	import bde_pkg::*;

	localparam int     ITEM_TARGET   = 1150;
	localparam int     CALM_FROM     = 1000;
	localparam int     SETTLE_CYCLES = 40;
	localparam int     HOLD_AFTER    = 400;
	localparam int     HOLD_CYCLES   = 300;
	localparam longint FRAC_ONE      = 64'sd65536;
	localparam longint ROUND_HALF    = 64'sd32768;

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0]     cfg_data;

	bde_in_if  ctrl_pts ();
	bde_out_if elev_pts ();

	bezier_degree_elevation DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.ctrl_pts  (ctrl_pts),
		.elev_pts  (elev_pts)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Control points waiting to be offered, and elevated points the block still
	// owes us, oldest first.
	pt_in_t  ctrl_pending_q[$];
	pt_out_t elevated_q[$];

	// Shadow of the block: degree and lane registers, the stored point and the
	// index of the next incoming point within its curve.
	int     degree_reg;
	int     lanes_reg;
	pt_in_t stored_pt;
	int     next_k;

	int  points_made;
	int  results_seen;
	int  mismatches;
	int  src_gap_pct;
	int  snk_gap_pct;
	bit  calm;

	// Weighted sum of two neighbors in Q16.16, rounded once to nearest with
	// ties toward plus infinity. The sum is exact in 64 bits.
	function automatic coord_t blend_lane(coord_t earlier, coord_t later, int unsigned alpha);
		longint acc;
		acc = longint'(alpha) * longint'(earlier)
			+ longint'(FRAC_ONE - alpha) * longint'(later) + ROUND_HALF;
		acc = acc >>> FRAC_W;
		return acc[COORD_W-1:0];
	endfunction

	// Lanes beyond the configured count read as zero.
	function automatic pt_out_t make_elevated(pt_in_t p, int idx, bit last);
		pt_out_t r;
		r.out_x       = (lanes_reg > 0) ? p.coord_x : '0;
		r.out_y       = (lanes_reg > 1) ? p.coord_y : '0;
		r.out_z       = (lanes_reg > 2) ? p.coord_z : '0;
		r.out_w       = (lanes_reg > 3) ? p.coord_w : '0;
		r.point_index = idx[IDX_W-1:0];
		r.last_point  = last;
		return r;
	endfunction

	// Works out the elevated points that one accepted control point causes.
	// An index above the current degree (the degree was lowered mid-curve)
	// restarts the curve. The last point of a curve, and the only point of a
	// degree-zero curve, also repeats itself as the closing point.
	function automatic void elevate_point(pt_in_t cur);
		int          k;
		int unsigned m;
		int unsigned alpha;
		pt_in_t      mix;
		k = next_k;
		if (k > degree_reg)
			k = 0;
		if (k == 0) begin
			elevated_q.push_back(make_elevated(cur, 0, 1'b0));
		end else begin
			m = degree_reg + 1;
			alpha = ((k << FRAC_W) + (m >> 1)) / m;
			mix.coord_x = blend_lane(stored_pt.coord_x, cur.coord_x, alpha);
			mix.coord_y = blend_lane(stored_pt.coord_y, cur.coord_y, alpha);
			mix.coord_z = blend_lane(stored_pt.coord_z, cur.coord_z, alpha);
			mix.coord_w = blend_lane(stored_pt.coord_w, cur.coord_w, alpha);
			elevated_q.push_back(make_elevated(mix, k, 1'b0));
		end
		if (k == degree_reg) begin
			elevated_q.push_back(make_elevated(cur, degree_reg + 1, 1'b1));
			next_k = 0;
		end else begin
			next_k = k + 1;
		end
		stored_pt = cur;
	endfunction

	function automatic pt_in_t make_input(coord_t x, coord_t y, coord_t z, coord_t w);
		pt_in_t p;
		p.coord_x = x;
		p.coord_y = y;
		p.coord_z = z;
		p.coord_w = w;
		return p;
	endfunction

	// Full-range values half the time, with the extremes and small values near zero
	// mixed in so that rounding ties and sign changes come up often.
	function automatic coord_t rand_coord();
		case ($urandom_range(0, 7))
			0:       return 32'h7FFF_FFFF;
			1:       return 32'h8000_0000;
			2:       return coord_t'($urandom_range(0, 8)) - 4;
			3:       return coord_t'($urandom_range(0, 32'h0003_FFFF)) - 32'sh0002_0000;
			default: return $urandom;
		endcase
	endfunction

	function automatic void queue_point(pt_in_t p);
		ctrl_pending_q.push_back(p);
		points_made++;
	endfunction

	function automatic void queue_random_point();
		queue_point(make_input(rand_coord(), rand_coord(), rand_coord(), rand_coord()));
	endfunction

	// One register write. The predictor takes the new value at the same edge
	// as the block; the block is idle whenever this runs.
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == CFG_CURVE_DEGREE) begin
			degree_reg = (val > MAX_DEGREE) ? MAX_DEGREE : val;
		end else begin
			lanes_reg = (val[DIM_W-1:0] > LANES) ? LANES : val[DIM_W-1:0];
		end
	endtask

	task automatic set_regs(input logic [CFG_W-1:0] degree, input logic [CFG_W-1:0] lanes);
		write_reg(CFG_CURVE_DEGREE, degree);
		write_reg(CFG_DIMENSION_COUNT, lanes);
	endtask

	// Waits until every queued point has been taken and every elevated point
	// has come back, then gives the divider and drain time to settle. Sampled
	// on the falling edge so the clocked processes have finished their update.
	task automatic wait_idle();
		do
			@(negedge clk);
		while (ctrl_pending_q.size() != 0 || ctrl_pts.valid || elevated_q.size() != 0);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic check_field(input string name, input longint want, input longint got);
		if (want != got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			mismatches++;
		end
	endtask

	// Source side: offers queued control points, one request at a time, with
	// random bursts of idle cycles between them. The predictor runs on every
	// accepted request.
	int src_gap;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctrl_pts.valid <= 1'b0;
			ctrl_pts.data  <= '0;
			src_gap = 0;
		end else begin
			if (ctrl_pts.valid && ctrl_pts.ready)
				elevate_point(ctrl_pts.data);
			if (!ctrl_pts.valid || ctrl_pts.ready) begin
				if (src_gap > 0) begin
					src_gap--;
					ctrl_pts.valid <= 1'b0;
				end else if (ctrl_pending_q.size() > 0) begin
					ctrl_pts.valid <= 1'b1;
					ctrl_pts.data  <= ctrl_pending_q.pop_front();
					if (!calm && $urandom_range(0, 99) < src_gap_pct)
						src_gap = $urandom_range(1, 3);
				end else begin
					ctrl_pts.valid <= 1'b0;
				end
			end
		end
	end

	// Sink side: checks every accepted elevated point against the oldest
	// prediction. Ready drops in short random bursts, and once, while the
	// source still has plenty queued, for a long stretch so that the single
	// output register fills and the block stops taking control points.
	int sink_gap;
	int hold_left;
	bit hold_done;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			elev_pts.ready <= 1'b0;
			sink_gap  = 0;
			hold_left = 0;
			hold_done = 1'b0;
		end else begin
			if (elev_pts.valid && elev_pts.ready) begin
				results_seen++;
				if (elevated_q.size() == 0) begin
					$error("elevated point with nothing expected: index %0d",
						elev_pts.data.point_index);
					mismatches++;
				end else begin
					pt_out_t want;
					want = elevated_q.pop_front();
					check_field("out_x", want.out_x, elev_pts.data.out_x);
					check_field("out_y", want.out_y, elev_pts.data.out_y);
					check_field("out_z", want.out_z, elev_pts.data.out_z);
					check_field("out_w", want.out_w, elev_pts.data.out_w);
					check_field("point_index", want.point_index, elev_pts.data.point_index);
					check_field("last_point", want.last_point, elev_pts.data.last_point);
				end
			end
			if (!hold_done && !calm && results_seen >= HOLD_AFTER && ctrl_pending_q.size() > 4) begin
				hold_left = HOLD_CYCLES;
				hold_done = 1'b1;
			end
			if (hold_left > 0) begin
				hold_left--;
				elev_pts.ready <= 1'b0;
			end else if (sink_gap > 0) begin
				sink_gap--;
				elev_pts.ready <= 1'b0;
			end else begin
				elev_pts.ready <= 1'b1;
				if (!calm && $urandom_range(0, 99) < snk_gap_pct)
					sink_gap = $urandom_range(1, 3);
			end
		end
	end

	initial begin
		int deg;
		int curves;
		int len;
		int c;
		int i;

		arst_n         = 1'b0;
		cfg_we         = 1'b0;
		cfg_index      = '0;
		cfg_data       = '0;
		degree_reg     = 3;
		lanes_reg      = 3;
		stored_pt      = '0;
		next_k         = 0;
		points_made    = 0;
		results_seen   = 0;
		mismatches     = 0;
		src_gap_pct    = 25;
		snk_gap_pct    = 25;
		calm           = 1'b0;

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Reset values of the registers: a cubic in three lanes, built from the
		// coordinate extremes so every blend spans the full range.
		queue_point(make_input(32'h7FFF_FFFF, 32'h8000_0000, 32'h0, -32'sd1));
		queue_point(make_input(32'h8000_0000, 32'h7FFF_FFFF, -32'sd1, 32'h0));
		queue_point(make_input(32'h0, -32'sd1, 32'h7FFF_FFFF, 32'h8000_0000));
		queue_point(make_input(-32'sd1, 32'h0, 32'h8000_0000, 32'h7FFF_FFFF));
		wait_idle();

		// Degree one puts alpha at exactly one half, so odd neighbors land on a
		// rounding tie; both signs must round toward plus infinity.
		set_regs(1, 4);
		queue_point(make_input(32'sd1, -32'sd1, 32'sd1, -32'sd1));
		queue_point(make_input(32'sd0, 32'sd0, 32'sd2, -32'sd2));
		queue_point(make_input(32'h8000_0000, 32'h7FFF_FFFF, 32'sd3, -32'sd3));
		queue_point(make_input(32'h7FFF_FFFF, 32'h8000_0000, -32'sd3, 32'sd3));
		wait_idle();

		// Degree zero: one point is a whole curve and comes back twice. First
		// with no lanes at all, then with a lane count above the lane limit.
		set_regs(0, 0);
		queue_point(make_input(32'h7FFF_FFFF, 32'h8000_0000, -32'sd1, 32'sd1));
		wait_idle();
		set_regs(0, 15);
		queue_point(make_input(32'h8000_0000, 32'h7FFF_FFFF, 32'sd1, -32'sd1));
		wait_idle();

		// Lowering the degree part way through a curve: the next point finds its
		// index above the new degree and starts a fresh curve.
		set_regs(5, 12);
		for (i = 0; i < 3; i++)
			queue_random_point();
		wait_idle();
		set_regs(1, 9);
		queue_random_point();
		queue_random_point();
		wait_idle();

		// Alternating bit patterns in two lanes.
		set_regs(2, 2);
		queue_point(make_input(32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555));
		queue_point(make_input(32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA));
		queue_point(make_input(32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555));
		wait_idle();

		// Random phases. Each picks a degree, mostly small, sometimes the
		// largest or zero, and a raw lane value over the whole register, then
		// sends complete curves with the odd one cut short.
		while (points_made < ITEM_TARGET) begin
			calm = (points_made >= CALM_FROM);
			case ($urandom_range(0, 19))
				0:       deg = 0;
				1, 2:    deg = MAX_DEGREE;
				default: deg = $urandom_range(1, 6);
			endcase
			case ($urandom_range(0, 3))
				0:       begin src_gap_pct = 0;  snk_gap_pct = 0;  end
				1:       begin src_gap_pct = 40; snk_gap_pct = 10; end
				2:       begin src_gap_pct = 10; snk_gap_pct = 40; end
				default: begin src_gap_pct = 25; snk_gap_pct = 25; end
			endcase
			if ($urandom_range(0, 3) != 0)
				write_reg(CFG_CURVE_DEGREE, CFG_W'(deg));
			if ($urandom_range(0, 3) != 0)
				write_reg(CFG_DIMENSION_COUNT, CFG_W'($urandom_range(0, 15)));
			curves = (degree_reg == MAX_DEGREE) ? $urandom_range(1, 3) : $urandom_range(2, 6);
			for (c = 0; c < curves; c++) begin
				len = degree_reg + 1;
				if ($urandom_range(0, 9) == 0)
					len = $urandom_range(1, degree_reg + 1);
				for (i = 0; i < len; i++)
					queue_random_point();
			end
			wait_idle();
		end

		if (elevated_q.size() != 0) begin
			$error("%0d elevated points never arrived", elevated_q.size());
			mismatches++;
		end
		if (mismatches == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

	initial begin
		#3_000_000;
		$display("*** FAILED ***");
		$finish;
	end

endmodule
